// ===== src/battery_power_state_and_idle_sleep_core_assert.svh =====
// Assertion macros used by the power-state step logic
`ifndef BATTERY_POWER_STATE_AND_IDLE_SLEEP_CORE_ASSERT_SVH
`define BATTERY_POWER_STATE_AND_IDLE_SLEEP_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, idle during reset
`define BPSIS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, idle during reset
`define BPSIS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/bpsis_pkg.sv =====
package bpsis_pkg;

    localparam int TIME_W   = 32;
    localparam int CHARGE_W = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_TIMEOUT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEEP_TIMEOUT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_CHARGE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_CHARGE   = 3'd4;

    // Reset values of the configuration registers
    localparam logic [TIME_W-1:0]   RST_IDLE_TIMEOUT  = 32'd300000;
    localparam logic [TIME_W-1:0]   RST_LIGHT_TIMEOUT = 32'd1800000;
    localparam logic [TIME_W-1:0]   RST_DEEP_TIMEOUT  = 32'd3600000;
    localparam logic [CHARGE_W-1:0] RST_LOW_CHARGE    = 7'd20;
    localparam logic [CHARGE_W-1:0] RST_FULL_CHARGE   = 7'd95;

    typedef enum logic [2:0] {
        MODE_NORMAL   = 3'd0,
        MODE_LOW      = 3'd1,
        MODE_CRITICAL = 3'd2,
        MODE_CHARGING = 3'd3,
        MODE_CHARGED  = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        SLEEP_NONE  = 2'd0,
        SLEEP_LIGHT = 2'd1,
        SLEEP_DEEP  = 2'd2
    } sleep_t;

    typedef struct packed {
        logic [TIME_W-1:0]   idle_limit_ms;
        logic [TIME_W-1:0]   light_timeout_ms;
        logic [TIME_W-1:0]   deep_timeout_ms;
        logic [CHARGE_W-1:0] low_charge_pct;
        logic [CHARGE_W-1:0] full_charge_pct;
    } cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0]   now_ms;
        logic                activity;
        logic [CHARGE_W-1:0] charge_pct;
        logic                battery_low;
        logic                battery_critical;
        logic                on_dock;
    } item_t;

    typedef struct packed {
        mode_t  power_mode;
        mode_t  prior_mode;
        logic   mode_changed;
        logic   idle_level;
        sleep_t sleep_request;
        logic   low_battery_flag;
        logic   emergency_flag;
    } res_t;

endpackage

// ===== src/battery_power_state_and_idle_sleep_core.sv =====
// A transaction accepted into the input register has its result registered in the
// output register when the output is not stalled; the result is held until taken.
// The block takes one transaction per cycle while the output is not stalled; while
// a result is stalled the input register takes one more transaction, then stalls.
// Reset (rst_n low, asynchronous): power mode and prior mode normal, level
// active, last activity time zero, configuration registers at their defaults.
module battery_power_state_and_idle_sleep_core
    import bpsis_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [TIME_W-1:0]     now_ms,
    input  logic                  activity,
    input  logic [CHARGE_W-1:0]   charge_pct,
    input  logic                  battery_low,
    input  logic                  battery_critical,
    input  logic                  on_dock,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [2:0]            power_mode,
    output logic [2:0]            prior_mode,
    output logic                  mode_changed,
    output logic                  idle_level,
    output logic [1:0]            sleep_request,
    output logic                  low_battery_flag,
    output logic                  emergency_flag
);

    cfg_t  cfg;
    item_t in_item_reg;
    logic  in_valid_reg, in_valid_next;
    res_t  out_res_reg;
    logic  out_valid_reg, out_valid_next;
    res_t  res;
    logic  advance;
    logic  in_take;

    bpsis_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bpsis_step u_step
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .item  (in_item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    // Move the held transaction on unless the output is blocked
    assign advance        = in_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall       = in_valid_reg && out_valid_reg && out_stall;
    assign in_take        = in_valid && !in_stall;
    assign in_valid_next  = in_take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    // Hold the valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture input and result payloads
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg.now_ms           <= now_ms;
            in_item_reg.activity         <= activity;
            in_item_reg.charge_pct       <= charge_pct;
            in_item_reg.battery_low      <= battery_low;
            in_item_reg.battery_critical <= battery_critical;
            in_item_reg.on_dock          <= on_dock;
        end
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid        = out_valid_reg;
    assign power_mode       = out_res_reg.power_mode;
    assign prior_mode       = out_res_reg.prior_mode;
    assign mode_changed     = out_res_reg.mode_changed;
    assign idle_level       = out_res_reg.idle_level;
    assign sleep_request    = out_res_reg.sleep_request;
    assign low_battery_flag = out_res_reg.low_battery_flag;
    assign emergency_flag   = out_res_reg.emergency_flag;

endmodule

// ===== src/bpsis_cfg.sv =====
module bpsis_cfg
    import bpsis_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write into the addressed register
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IDLE_TIMEOUT:  cfg_next.idle_limit_ms    = cfg_data[TIME_W-1:0];
                CFG_LIGHT_TIMEOUT: cfg_next.light_timeout_ms = cfg_data[TIME_W-1:0];
                CFG_DEEP_TIMEOUT:  cfg_next.deep_timeout_ms  = cfg_data[TIME_W-1:0];
                CFG_LOW_CHARGE:    cfg_next.low_charge_pct   = cfg_data[CHARGE_W-1:0];
                CFG_FULL_CHARGE:   cfg_next.full_charge_pct  = cfg_data[CHARGE_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.idle_limit_ms    <= RST_IDLE_TIMEOUT;
            cfg_reg.light_timeout_ms <= RST_LIGHT_TIMEOUT;
            cfg_reg.deep_timeout_ms  <= RST_DEEP_TIMEOUT;
            cfg_reg.low_charge_pct   <= RST_LOW_CHARGE;
            cfg_reg.full_charge_pct  <= RST_FULL_CHARGE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/bpsis_step.sv =====
`include "battery_power_state_and_idle_sleep_core_assert.svh"

module bpsis_step
    import bpsis_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  fire,
    input  item_t item,
    input  cfg_t  cfg,
    output res_t  res
);

    mode_t             mode_reg, mode_next;
    mode_t             prior_mode_reg, prior_mode_next;
    logic              level_reg, level_next;
    logic [TIME_W-1:0] last_act_reg, last_act_next;

    logic [TIME_W-1:0] last_pre;
    logic              level_pre;
    logic [TIME_W-1:0] elapsed;
    mode_t             mode_sel;
    sleep_t            req;
    logic              escalate;

    // Apply reported activity before measuring idle time
    assign last_pre  = item.activity ? item.now_ms : last_act_reg;
    assign level_pre = item.activity ? 1'b0 : level_reg;
    assign elapsed   = item.now_ms - last_pre;
    assign escalate  = !item.on_dock && (mode_reg == MODE_NORMAL);

    // Pick the power mode by priority
    always_comb
    begin
        priority if (item.battery_critical && !item.on_dock)
            mode_sel = MODE_CRITICAL;
        else if (item.battery_low && !item.on_dock)
            mode_sel = MODE_LOW;
        else if (item.on_dock)
            mode_sel = (item.charge_pct >= cfg.full_charge_pct) ? MODE_CHARGED
                                                                : MODE_CHARGING;
        else
            mode_sel = MODE_NORMAL;
    end

    // Escalate idle time, then apply any mode change
    always_comb
    begin
        req             = SLEEP_NONE;
        last_act_next   = last_pre;
        level_next      = level_pre;
        mode_next       = mode_reg;
        prior_mode_next = prior_mode_reg;

        if (escalate)
        begin
            priority if (elapsed > cfg.deep_timeout_ms
                         && item.charge_pct < cfg.low_charge_pct)
            begin
                req           = SLEEP_DEEP;
                last_act_next = item.now_ms;
            end
            else if (elapsed > cfg.light_timeout_ms)
            begin
                req           = SLEEP_LIGHT;
                last_act_next = item.now_ms;
                level_next    = 1'b0;
            end
            else if (elapsed > cfg.idle_limit_ms && !level_pre)
            begin
                level_next = 1'b1;
            end
        end
        else
        begin
            last_act_next = item.now_ms;
            level_next    = 1'b0;
        end

        if (mode_sel != mode_reg)
        begin
            prior_mode_next = mode_reg;
            mode_next       = mode_sel;
            last_act_next   = item.now_ms;
            level_next      = 1'b0;
        end
    end

    // Form the result from the updated state
    always_comb
    begin
        res.power_mode       = mode_next;
        res.prior_mode       = prior_mode_next;
        res.mode_changed     = (mode_sel != mode_reg);
        res.idle_level       = level_next;
        res.sleep_request    = req;
        res.low_battery_flag = (mode_next == MODE_LOW) || (mode_next == MODE_CRITICAL);
        res.emergency_flag   = (mode_next == MODE_CRITICAL);
    end

    // Advance the state once per transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_NORMAL;
            prior_mode_reg <= MODE_NORMAL;
            level_reg      <= 1'b0;
            last_act_reg   <= '0;
        end
        else if (fire)
        begin
            mode_reg       <= mode_next;
            prior_mode_reg <= prior_mode_next;
            level_reg      <= level_next;
            last_act_reg   <= last_act_next;
        end
    end

    `BPSIS_ASSERT_NOW(a_change_clears_idle, fire && res.mode_changed, !res.idle_level,
        "mode change left the level idle")
    `BPSIS_ASSERT_NOW(a_deep_needs_low_charge, fire && res.sleep_request == SLEEP_DEEP,
        item.charge_pct < cfg.low_charge_pct, "deep sleep requested above low charge")
    `BPSIS_ASSERT_NOW(a_docked_charging, fire && item.on_dock,
        res.power_mode == MODE_CHARGING || res.power_mode == MODE_CHARGED,
        "docked but not in a charging mode")
    `BPSIS_ASSERT_NEXT(a_sleep_restarts_timer, fire && res.sleep_request != SLEEP_NONE,
        last_act_reg == $past(item.now_ms), "sleep request did not restart activity time")

endmodule
